### rtl/core/rrvi_pkg.sv
`default_nettype none
package rrvi_pkg;

  // field and register widths
  localparam int PRICE_W    = 24;
  localparam int OUT_W      = 23;
  localparam int EMA_W      = 11;
  localparam int NREG_W     = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_EMA_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REG_PERIOD = 2'd1;

  // register reset values
  localparam logic [EMA_W-1:0]  EMA_PERIOD_RST = 11'd5;
  localparam logic [NREG_W-1:0] REG_PERIOD_RST = 7'd10;

  localparam int MAX_WINDOW_DEF = 64;

  // serial datapath widths
  localparam int DP_W      = 72;  // multiplier accumulator and dividend
  localparam int MUL_W     = 32;  // multiplier operand consumed one bit per cycle
  localparam int DEN_W     = 64;  // divisor
  localparam int DIV_CNT_W = 7;
  localparam int ENERGY_W  = 64;
  localparam int NORM_W    = 40;  // energies scaled below 2^40 for the ratio

  localparam logic [OUT_W-1:0] HALF_INDEX = 23'd3276800;
  localparam logic [OUT_W-1:0] FULL_INDEX = 23'd6553600;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SUMS,
    S_P0,
    S_MT1,
    S_MT2,
    S_MT3,
    S_RDIV_GO,
    S_RDIV,
    S_SQ,
    S_EDIV,
    S_EMA,
    S_SDIV,
    S_NORM0,
    S_NORM,
    S_IMUL,
    S_IDIV,
    S_EMIT
  } state_t;

endpackage
`default_nettype wire

### rtl/core/regression_residual_volatility_index_top.sv
`default_nettype none
// Channel   Direction  Handshake               Payload
// input     in         in_valid / in_stall     price[23:0]
// result    out        out_valid / out_stall   index_value[22:0]
// config    in         cfg_write               cfg_index[1:0], cfg_data[10:0]
//
// One item at a time. A warm-up item runs the accept cycle and the weight multiply.
// An item with a result also runs the bit-serial divider (up to four divisions per
// item) and the shift-add multiplier (one multiplier bit per cycle, up to six
// products per item).
// Reset (rst, synchronous) clears pointers, sums, energies and the result beat.
// The next item is taken while a result beat waits under out_stall; a new result
// waits in the sequencer until the output register frees.
module regression_residual_volatility_index_top
  import rrvi_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PRICE_W-1:0]    price,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [OUT_W-1:0]      index_value,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH = MAX_WINDOW + 1;
  localparam int PW    = $clog2(DEPTH);
  localparam int NW    = $clog2(MAX_WINDOW + 1);
  localparam int AW    = 2 * NW;
  localparam int QW    = 3 * NW;
  localparam int N6W   = NW + 3;
  localparam int SYW   = PRICE_W + NW;
  localparam int SXYW  = PRICE_W + 2 * NW;

  state_t state, state_next;

  logic [EMA_W-1:0]  ema_period;
  logic [NREG_W-1:0] regression_period;
  logic [NW-1:0]     n_len;
  logic [AW-1:0]     a_len;
  logic [QW-1:0]     q_len;
  logic [N6W-1:0]    n6;

  logic [PRICE_W-1:0] hist [DEPTH];
  logic [PW-1:0]      wp, wp_inc, raddr;
  logic [NW-1:0]      fc;
  logic               fill;
  logic [SYW-1:0]     sy;
  logic [SXYW-1:0]    sxy;
  logic [PRICE_W-1:0] y_q, old_q;
  logic               seed_q, up_q;

  logic [DP_W-1:0]        t1, t2;
  logic signed [DP_W-1:0] p;
  logic                   p_neg;
  logic [DP_W-1:0]        mag;
  logic                   sat;

  logic [ENERGY_W-1:0] up_energy, down_energy, e_q, cur_e, diff, step;
  logic                e_ge;
  logic [EMA_W-1:0]    ema_eff;
  logic [ENERGY_W-1:0] g_w, l_w;
  logic [NORM_W:0]     s_w;
  logic                both_zero, too_big;
  logic [OUT_W-1:0]    res_q;
  logic                out_free;

  // shift-add multiplier
  logic            mul_load, mul_done;
  logic [DP_W-1:0] mul_a, m_acc, m_cand;
  logic [MUL_W-1:0] mul_b, m_mult;

  // restoring divider
  logic                 div_load, div_done;
  logic [DP_W-1:0]      div_n, d_num;
  logic [DEN_W-1:0]     div_d, d_den, d_rem;
  logic [DEN_W:0]       d_trial;
  logic [DIV_CNT_W-1:0] d_cnt;

  // effective window length
  always_comb begin
    if (regression_period < NREG_W'(2)) begin
      n_len = NW'(2);
    end else if (int'(regression_period) > MAX_WINDOW) begin
      n_len = NW'(MAX_WINDOW);
    end else begin
      n_len = NW'(regression_period);
    end
  end

  // window constants, registered; q_len is built from the registered a_len
  always_ff @(posedge clk) begin
    a_len <= AW'(n_len) * (AW'(n_len) + AW'(1));
    q_len <= QW'(n_len) * QW'(a_len);
    n6    <= N6W'(n_len) * N6W'(6);
  end

  // pointers and misc datapath terms
  always_comb begin
    fill      = fc < n_len;
    wp_inc    = (int'(wp) == DEPTH - 1) ? '0 : wp + PW'(1);
    raddr     = (PW + 1)'(wp) >= (PW + 1)'(n_len)
              ? PW'((PW + 1)'(wp) - (PW + 1)'(n_len))
              : PW'((PW + 1)'(wp) + (PW + 1)'(DEPTH) - (PW + 1)'(n_len));
    p_neg     = p[DP_W-1];
    mag       = p_neg ? DP_W'(-p) : DP_W'(p);
    sat       = |d_num[DP_W-1:MUL_W];
    cur_e     = up_q ? up_energy : down_energy;
    e_ge      = e_q >= cur_e;
    diff      = e_ge ? e_q - cur_e : cur_e - e_q;
    step      = d_num[ENERGY_W-1:0];
    ema_eff   = (ema_period == '0) ? EMA_W'(1) : ema_period;
    both_zero = (g_w == '0) && (l_w == '0);
    too_big   = |(g_w[ENERGY_W-1:NORM_W] | l_w[ENERGY_W-1:NORM_W]);
    out_free  = !out_valid || !out_stall;
    mul_done  = m_mult == '0;
    div_done  = d_cnt == '0;
  end

  // history memory, registered read of the oldest price
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      hist[wp] <= price;
      old_q    <= hist[raddr];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:    if (in_valid) state_next = S_SUMS;
      S_SUMS: begin
        if (mul_done) begin
          if (seed_q && (fc + NW'(1) < n_len)) state_next = S_IDLE;
          else state_next = S_P0;
        end
      end
      S_P0:      state_next = S_MT1;
      S_MT1:     if (mul_done) state_next = S_MT2;
      S_MT2:     if (mul_done) state_next = S_MT3;
      S_MT3:     if (mul_done) state_next = S_RDIV_GO;
      S_RDIV_GO: state_next = S_RDIV;
      S_RDIV:    if (div_done) state_next = sat ? S_EMA : S_SQ;
      S_SQ:      if (mul_done) state_next = S_EDIV;
      S_EDIV:    if (div_done) state_next = S_EMA;
      S_EMA:     state_next = seed_q ? S_NORM0 : S_SDIV;
      S_SDIV:    if (div_done) state_next = S_NORM0;
      S_NORM0:   state_next = S_NORM;
      S_NORM: begin
        if (both_zero) state_next = S_EMIT;
        else if (!too_big) state_next = S_IMUL;
      end
      S_IMUL:    if (mul_done) state_next = S_IDIV;
      S_IDIV:    if (div_done) state_next = S_EMIT;
      S_EMIT:    if (out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // sequencer outputs: handshake and operand loads of the shared units
  always_comb begin
    in_stall = state != S_IDLE;
    mul_load = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    div_load = 1'b0;
    div_n    = '0;
    div_d    = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          mul_load = 1'b1;
          mul_a    = DP_W'(price);
          mul_b    = MUL_W'(fill ? fc + NW'(1) : n_len);
        end
      end
      S_P0: begin
        mul_load = 1'b1;
        mul_a    = DP_W'(q_len);
        mul_b    = MUL_W'(y_q);
      end
      S_MT1: begin
        if (mul_done) begin
          mul_load = 1'b1;
          mul_a    = DP_W'(sy);
          mul_b    = MUL_W'(a_len);
        end
      end
      S_MT2: begin
        if (mul_done) begin
          mul_load = 1'b1;
          mul_a    = DP_W'(sxy);
          mul_b    = MUL_W'(n6);
        end
      end
      S_RDIV_GO: begin
        div_load = 1'b1;
        div_n    = (mag << 8) + DP_W'(q_len >> 1);
        div_d    = DEN_W'(q_len);
      end
      S_RDIV: begin
        if (div_done && !sat) begin
          mul_load = 1'b1;
          mul_a    = DP_W'(d_num[MUL_W-1:0]);
          mul_b    = d_num[MUL_W-1:0];
        end
      end
      S_SQ: begin
        if (mul_done) begin
          div_load = 1'b1;
          div_n    = m_acc;
          div_d    = DEN_W'(n_len);
        end
      end
      S_EMA: begin
        if (!seed_q) begin
          div_load = 1'b1;
          div_n    = DP_W'({diff, 1'b0});
          div_d    = DEN_W'(ema_eff) + DEN_W'(1);
        end
      end
      S_NORM: begin
        if (!both_zero && !too_big) begin
          mul_load = 1'b1;
          mul_a    = DP_W'(g_w);
          mul_b    = MUL_W'(FULL_INDEX);
        end
      end
      S_IMUL: begin
        if (mul_done) begin
          div_load = 1'b1;
          div_n    = m_acc + DP_W'(s_w >> 1);
          div_d    = DEN_W'(s_w);
        end
      end
      default: ;
    endcase
  end

  // multiplier: one multiplier bit per cycle until it runs out
  always_ff @(posedge clk) begin
    if (rst) begin
      m_mult <= '0;
    end else if (mul_load) begin
      m_acc  <= '0;
      m_cand <= mul_a;
      m_mult <= mul_b;
    end else if (!mul_done) begin
      if (m_mult[0]) m_acc <= m_acc + m_cand;
      m_cand <= m_cand << 1;
      m_mult <= m_mult >> 1;
    end
  end

  // divider: one quotient bit per cycle, quotient shifts into d_num
  assign d_trial = {d_rem, d_num[DP_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      d_cnt <= '0;
    end else if (div_load) begin
      d_num <= div_n;
      d_den <= div_d;
      d_rem <= '0;
      d_cnt <= DIV_CNT_W'(DP_W);
    end else if (!div_done) begin
      if (d_trial >= {1'b0, d_den}) begin
        d_rem <= DEN_W'(d_trial - {1'b0, d_den});
        d_num <= {d_num[DP_W-2:0], 1'b1};
      end else begin
        d_rem <= d_trial[DEN_W-1:0];
        d_num <= {d_num[DP_W-2:0], 1'b0};
      end
      d_cnt <= d_cnt - DIV_CNT_W'(1);
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // item datapath and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      ema_period        <= EMA_PERIOD_RST;
      regression_period <= REG_PERIOD_RST;
      wp                <= '0;
      fc                <= '0;
      sy                <= '0;
      sxy               <= '0;
      up_energy         <= '0;
      down_energy       <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            y_q    <= price;
            seed_q <= fill;
            wp     <= wp_inc;
          end
        end
        S_SUMS: begin
          if (mul_done) begin
            if (seed_q) begin
              fc  <= fc + NW'(1);
              sy  <= sy + SYW'(y_q);
              sxy <= sxy + SXYW'(m_acc);
            end else begin
              sxy <= SXYW'(DP_W'(sxy) - DP_W'(sy) + m_acc);
              sy  <= sy - SYW'(old_q) + SYW'(y_q);
            end
          end
        end
        S_MT1: if (mul_done) t1 <= m_acc;
        S_MT2: if (mul_done) t2 <= m_acc;
        S_MT3: if (mul_done) p <= $signed(t1 + (t2 << 1) - m_acc);
        S_RDIV: begin
          if (div_done) begin
            up_q <= !p_neg && (p != '0) && (d_num != '0);
            if (sat) e_q <= '1;
          end
        end
        S_EDIV: if (div_done) e_q <= d_num[ENERGY_W-1:0];
        S_EMA: begin
          // first full window seeds the chosen energy
          if (seed_q) begin
            if (up_q) up_energy <= e_q;
            else down_energy <= e_q;
          end
        end
        S_SDIV: begin
          if (div_done) begin
            if (up_q) up_energy <= e_ge ? up_energy + step : up_energy - step;
            else down_energy <= e_ge ? down_energy + step : down_energy - step;
          end
        end
        S_NORM0: begin
          g_w <= up_energy;
          l_w <= down_energy;
        end
        S_NORM: begin
          if (both_zero) begin
            res_q <= HALF_INDEX;
          end else if (too_big) begin
            g_w <= g_w >> 1;
            l_w <= l_w >> 1;
          end else begin
            s_w <= (NORM_W + 1)'(g_w[NORM_W-1:0]) + (NORM_W + 1)'(l_w[NORM_W-1:0]);
          end
        end
        S_IDIV: if (div_done) res_q <= d_num[OUT_W-1:0];
        default: ;
      endcase

      // register writes must arrive only while idle; the block itself does not enforce this
      if (cfg_write) begin
        case (cfg_index)
          CFG_EMA_PERIOD: ema_period <= cfg_data[EMA_W-1:0];
          CFG_REG_PERIOD: begin
            regression_period <= cfg_data[NREG_W-1:0];
            wp                <= '0;
            fc                <= '0;
            sy                <= '0;
            sxy               <= '0;
            up_energy         <= '0;
            down_energy       <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      out_valid   <= 1'b1;
      index_value <= res_q;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> index_value <= FULL_INDEX)
    else $error("index above 100 percent");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fc <= n_len)
    else $error("fill count beyond window length");

  a_emit_only: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_EMIT))
    else $error("result beat raised outside emit");

endmodule
`default_nettype wire
